// ----- design/dsr_pkg.sv -----
// Shared types and constants for the DMX512 slot receiver.
package dsr_pkg;

	localparam int MAX_CHANNELS = 4;
	localparam int CH_AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	localparam int CNT_W = 10;
	localparam int BASE_W = 9;
	localparam int WIN_W = CNT_W + 1;
	localparam int CFG_W = 10;
	localparam int CFG_AW = 2;

	localparam logic [WIN_W-1:0] WIN_LEN = WIN_W'(MAX_CHANNELS);

	localparam logic [1:0] ST_UNSYNCED = 2'd0;
	localparam logic [1:0] ST_WAIT = 2'd1;
	localparam logic [1:0] ST_PAYLOAD = 2'd2;

	localparam logic [CFG_AW-1:0] REG_BASE = 2'd0;
	localparam logic [CFG_AW-1:0] REG_RELAY = 2'd1;
	localparam logic [CFG_AW-1:0] REG_LIMIT = 2'd2;

	localparam logic [7:0] START_CODE = 8'h00;
	localparam logic [7:0] RELAY_ON = 8'hFA;
	localparam logic [7:0] RELAY_OFF = 8'h00;
	localparam logic [7:0] RELAY_THRESH = 8'd64;
	localparam logic [CNT_W-1:0] LIMIT_RESET = 10'd128;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       framing_error;
	} item_t;

	typedef struct packed {
		logic       level_write;
		logic [1:0] channel_index;
		logic [7:0] level_value;
		logic       chain_end;
		logic [1:0] sync_state;
	} result_t;

	typedef struct packed {
		logic             we;
		logic [CH_AW-1:0] addr;
		logic [7:0]       data;
	} lvl_wr_t;

	typedef struct packed {
		logic             level_write;
		logic [1:0]       channel_index;
		logic [CH_AW-1:0] addr;
		logic             chain_end;
		logic [1:0]       sync_state;
	} slot_res_t;

endpackage

// ----- design/dmx512_slot_receiver_core.sv -----
// Top level of the DMX512 slot receiver: handshakes, level memory and result register.
//
// Takes one received byte with its framing flag per transfer and returns one result per
// item. A new item is taken every clock while results are drained; each result passes
// through the first result stage, captured with the state update and level memory
// write, and then the result register, loaded with the registered memory read that
// supplies level_value. The sync state and slot counter update at the edge that accepts
// each item, so back-to-back items need no interlock. No clearing pass is needed after reset.
module dmx512_slot_receiver_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  dsr_pkg::item_t            item,
	output logic                      result_valid,
	input  logic                      result_ready,
	output dsr_pkg::result_t          result,
	input  logic                      cfg_we,
	input  logic [dsr_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [dsr_pkg::CFG_W-1:0] cfg_wdata
);
	import dsr_pkg::*;

	logic      valid_s1;
	slot_res_t res_s1;
	lvl_wr_t   lvl_wr;
	logic      advance;
	logic      accept;
	logic      move;
	logic [7:0] rd_level;

	logic       out_valid_q;
	logic       wr_q;
	logic [1:0] idx_q;
	logic       chain_q;
	logic [1:0] state_q;

	assign advance = !out_valid_q || result_ready;
	assign item_ready = !valid_s1 || advance;
	assign accept = item_valid && item_ready;
	assign move = valid_s1 && advance;

	dsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.advance   (advance),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.valid_s1  (valid_s1),
		.res_s1    (res_s1),
		.lvl_wr    (lvl_wr)
	);

	dsr_level_ram u_ram (
		.clk   (clk),
		.wr    (lvl_wr),
		.re    (move),
		.raddr (res_s1.addr),
		.rdata (rd_level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			wr_q <= res_s1.level_write;
			idx_q <= res_s1.channel_index;
			chain_q <= res_s1.chain_end;
			state_q <= res_s1.sync_state;
		end
	end

	assign result_valid = out_valid_q;
	assign result.level_write = wr_q;
	assign result.channel_index = idx_q;
	assign result.level_value = wr_q ? rd_level : 8'd0;
	assign result.chain_end = chain_q;
	assign result.sync_state = state_q;

endmodule

// ----- design/dsr_level_ram.sv -----
// Channel level memory: one write port, one registered read port.
module dsr_level_ram (
	input  logic                   clk,
	input  dsr_pkg::lvl_wr_t       wr,
	input  logic                   re,
	input  logic [dsr_pkg::CH_AW-1:0] raddr,
	output logic [7:0]             rdata
);
	import dsr_pkg::*;

	logic [7:0] mem [MAX_CHANNELS];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/dsr_ctrl.sv -----
// Sync state machine, slot counter, config registers and first result stage.
module dsr_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  dsr_pkg::item_t            item,
	input  logic                      advance,
	input  logic                      cfg_we,
	input  logic [dsr_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [dsr_pkg::CFG_W-1:0] cfg_wdata,
	output logic                      valid_s1,
	output dsr_pkg::slot_res_t        res_s1,
	output dsr_pkg::lvl_wr_t          lvl_wr
);
	import dsr_pkg::*;

	logic [BASE_W-1:0] base_q;
	logic              relay_q;
	logic [CNT_W-1:0]  limit_q;
	logic [1:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [WIN_W-1:0] cnt_ext;
	logic [WIN_W-1:0] base_ext;
	logic [WIN_W-1:0] win_end;
	logic [CNT_W-1:0] ch_off;
	logic [CNT_W-1:0] cnt_inc;
	logic             in_win;
	logic [7:0]       lv;
	logic [1:0]       state_d;
	logic [CNT_W-1:0] cnt_d;
	slot_res_t        res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			relay_q <= 1'b0;
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_BASE: base_q <= cfg_wdata[BASE_W-1:0];
				REG_RELAY: relay_q <= cfg_wdata[0];
				REG_LIMIT: limit_q <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cnt_ext = {1'b0, cnt_q};
	assign base_ext = {{(WIN_W-BASE_W){1'b0}}, base_q};
	assign win_end = base_ext + WIN_LEN;
	assign in_win = (cnt_ext >= base_ext) && (cnt_ext < win_end);
	assign ch_off = cnt_q - {{(CNT_W-BASE_W){1'b0}}, base_q};
	assign cnt_inc = cnt_q + CNT_W'(1);

	always_comb begin
		if (relay_q) begin
			lv = (item.rx_byte < RELAY_THRESH) ? RELAY_ON : RELAY_OFF;
		end else begin
			lv = item.rx_byte;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		res_d = '0;
		case (state_q)
			ST_WAIT: begin
				if (item.rx_byte == START_CODE) begin
					state_d = ST_PAYLOAD;
				end
			end
			ST_PAYLOAD: begin
				res_d.level_write = in_win;
				res_d.channel_index = in_win ? ch_off[1:0] : 2'd0;
				res_d.chain_end = (cnt_ext == win_end);
				cnt_d = cnt_inc;
				if (cnt_inc >= limit_q) begin
					state_d = ST_UNSYNCED;
				end
			end
			default: begin
				state_d = ST_UNSYNCED;
				if (item.framing_error) begin
					cnt_d = '0;
					state_d = ST_WAIT;
				end
			end
		endcase
		res_d.addr = ch_off[CH_AW-1:0];
		res_d.sync_state = state_d;
	end

	assign lvl_wr.we = accept && res_d.level_write;
	assign lvl_wr.addr = ch_off[CH_AW-1:0];
	assign lvl_wr.data = lv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_UNSYNCED;
			cnt_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= state_d;
				cnt_q <= cnt_d;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_d;
		end
	end

endmodule

// ----- verif/dmx512_slot_receiver_core_tb.sv -----
// Testbench for the DMX512 slot receiver core: predicts each slot result and checks every output transfer.
`timescale 1ns / 100ps

module dmx512_slot_receiver_core_tb;
	import dsr_pkg::*;

	localparam logic [CFG_AW-1:0] REG_UNUSED = 2'd3;

	class slot_scoreboard;
		logic [BASE_W-1:0] base_addr;
		logic              relay_on;
		logic [CNT_W-1:0]  slot_limit;
		logic [1:0]        rx_state;
		logic [CNT_W-1:0]  slot_cnt;
		logic [7:0]        levels [MAX_CHANNELS];
		result_t           slot_results_q[$];
		int                errors;

		function new();
			base_addr = '0;
			relay_on = 1'b0;
			slot_limit = LIMIT_RESET;
			rx_state = ST_UNSYNCED;
			slot_cnt = '0;
			foreach (levels[i]) levels[i] = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_BASE:  base_addr = val[BASE_W-1:0];
				REG_RELAY: relay_on = val[0];
				REG_LIMIT: slot_limit = val[CNT_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return slot_results_q.size();
		endfunction

		// Advance the receiver by one byte and queue the slot result it yields.
		function void note_byte(item_t it);
			result_t     r;
			logic [10:0] win_end;
			logic [10:0] chan;
			logic [7:0]  lvl;
			r = '0;
			if (rx_state == ST_WAIT) begin
				if (it.rx_byte == START_CODE) rx_state = ST_PAYLOAD;
			end else if (rx_state == ST_PAYLOAD) begin
				win_end = {2'b00, base_addr} + WIN_LEN;
				if ({1'b0, slot_cnt} >= {2'b00, base_addr} && {1'b0, slot_cnt} < win_end) begin
					chan = {1'b0, slot_cnt} - {2'b00, base_addr};
					if (relay_on)
						lvl = (it.rx_byte < RELAY_THRESH) ? RELAY_ON : RELAY_OFF;
					else
						lvl = it.rx_byte;
					levels[chan] = lvl;
					r.level_write = 1'b1;
					r.channel_index = chan[1:0];
					r.level_value = lvl;
				end
				if ({1'b0, slot_cnt} == win_end) r.chain_end = 1'b1;
				slot_cnt = slot_cnt + 10'd1;
				if (slot_cnt >= slot_limit) rx_state = ST_UNSYNCED;
			end else begin
				rx_state = ST_UNSYNCED;
				if (it.framing_error) begin
					slot_cnt = '0;
					rx_state = ST_WAIT;
				end
			end
			r.sync_state = rx_state;
			slot_results_q.push_back(r);
		endfunction

		function void cmp_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
			if (got_v !== exp_v) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
				errors++;
			end
		endfunction

		function void check_slot_result(result_t got);
			result_t exp_r;
			if (slot_results_q.size() == 0) begin
				$display("%0t: result with none expected, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			exp_r = slot_results_q.pop_front();
			cmp_field("level_write", 8'(exp_r.level_write), 8'(got.level_write));
			cmp_field("channel_index", 8'(exp_r.channel_index), 8'(got.channel_index));
			cmp_field("level_value", exp_r.level_value, got.level_value);
			cmp_field("chain_end", 8'(exp_r.chain_end), 8'(got.chain_end));
			cmp_field("sync_state", 8'(exp_r.sync_state), 8'(got.sync_state));
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_ready;
	item_t             item = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	result_t           result;
	logic              cfg_we = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [CFG_W-1:0]  cfg_wdata = '0;

	bit                gaps_on = 1'b1;
	bit                long_hold = 1'b0;
	int unsigned       cur_limit = LIMIT_RESET;

	slot_scoreboard sb = new();

	dmx512_slot_receiver_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) sb.note_byte(item);
			if (result_valid && result_ready) sb.check_slot_result(result);
		end
	end

	// Output side: random stall per transfer, plus one long hold-off on request.
	initial begin
		int unsigned stall;
		wait (arst_n);
		forever begin
			if (long_hold) begin
				result_ready <= 1'b0;
				repeat (60) @(posedge clk);
				long_hold = 1'b0;
			end
			stall = gaps_on ? $urandom_range(0, 5) : 0;
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
		end
	end

	initial begin
		#400000;
		$display("Mismatches found");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic fe);
		int unsigned gap;
		item_t it;
		gap = gaps_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.rx_byte = b;
		it.framing_error = fe;
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_cfg(input logic [CFG_W-1:0] base, input logic [CFG_W-1:0] relay,
		input logic [CFG_W-1:0] lim);
		logic [CFG_W-1:0] junk;
		junk = CFG_W'($urandom_range(0, 1023));
		cfg_we <= 1'b1;
		cfg_addr <= REG_UNUSED;
		cfg_wdata <= junk;
		@(posedge clk);
		cfg_addr <= REG_BASE;
		cfg_wdata <= base;
		@(posedge clk);
		cfg_addr <= REG_RELAY;
		cfg_wdata <= relay;
		@(posedge clk);
		cfg_addr <= REG_LIMIT;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(REG_UNUSED, junk);
		sb.write_reg(REG_BASE, base);
		sb.write_reg(REG_RELAY, relay);
		sb.write_reg(REG_LIMIT, lim);
		cur_limit = lim;
	endtask

	// Break, optional junk while waiting, start code, then slots up to the limit.
	task automatic send_frame(input int unsigned lim, output int unsigned n);
		int unsigned waits;
		int unsigned slots;
		n = 0;
		send_byte(8'($urandom_range(0, 255)), 1'b1);
		n++;
		waits = $urandom_range(0, 2);
		repeat (waits) begin
			send_byte(8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
			n++;
		end
		send_byte(START_CODE, 1'($urandom_range(0, 1)));
		n++;
		slots = (lim == 0) ? 1 : lim;
		repeat (slots) begin
			send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			n++;
		end
	endtask

	task automatic send_traffic(input int unsigned target);
		int unsigned done;
		int unsigned n;
		int unsigned kind;
		int unsigned k;
		done = 0;
		while (done < target) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				k = $urandom_range(1, 4);
				repeat (k) send_byte(8'($urandom_range(0, 255)), 1'b0);
				done += k;
			end else if (kind == 1) begin
				// aborted frame: break and a few bytes, no start code
				send_byte(8'($urandom_range(1, 255)), 1'b1);
				k = $urandom_range(1, 3);
				repeat (k) send_byte(8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
				done += k + 1;
			end else begin
				send_frame(cur_limit, n);
				done += n;
			end
		end
	endtask

	initial begin
		int unsigned n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: base 0, level mode, limit 128
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h55, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(START_CODE, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h3F, 1'b0);
		send_byte(8'h40, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h01, 1'b1);
		drain_results();

		// relay mode around the threshold, chain end and resync at a small limit
		set_cfg(10'd2, 10'd1, 10'd8);
		send_byte(8'hC3, 1'b1);
		send_byte(START_CODE, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h3F, 1'b0);
		send_byte(8'h40, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h7E, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'h00, 1'b0);
		drain_results();

		set_cfg(10'd0, 10'd0, 10'd1);
		send_traffic(80);
		drain_results();

		// highest base with the largest nominal limit, one full frame
		set_cfg(10'h1FF, 10'h3FF, 10'd512);
		send_frame(cur_limit, n);
		drain_results();

		gaps_on = 1'b0;
		set_cfg(10'h200, 10'd1, 10'd4);
		send_traffic(100);
		drain_results();
		gaps_on = 1'b1;

		set_cfg(10'd0, 10'd0, 10'd0);
		send_traffic(40);
		drain_results();

		// limit lowered below the counter while in payload
		set_cfg(10'd1, 10'd0, 10'd100);
		send_byte(8'h9C, 1'b1);
		send_byte(START_CODE, 1'b0);
		repeat (10) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		drain_results();
		set_cfg(10'd1, 10'd0, 10'd5);
		send_byte(8'h21, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hE7, 1'b0);
		send_traffic(40);
		drain_results();

		// output held off while input keeps streaming
		set_cfg(10'd3, 10'd0, 10'd12);
		gaps_on = 1'b0;
		long_hold = 1'b1;
		send_traffic(40);
		drain_results();
		gaps_on = 1'b1;

		repeat (5) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			set_cfg(CFG_W'($urandom_range(0, 20) | ($urandom_range(0, 1) << 9)),
				CFG_W'($urandom_range(0, 1023)), CFG_W'($urandom_range(1, 40)));
			send_traffic(100);
			drain_results();
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/dsr_pkg.sv
design/dsr_level_ram.sv
design/dsr_ctrl.sv
design/dmx512_slot_receiver_core.sv
verif/dmx512_slot_receiver_core_tb.sv
